// ===== rtl/atan2_pkg.sv =====
// package for the whole-degree arctangent block: widths, table and threshold helpers
package atan2_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH      = 9;
    localparam int SCALE_SHIFT      = 6;
    localparam int TABLE_LEN        = 346;
    localparam int TABLE_IDX_W      = 9;
    localparam int FQ_WIDTH         = 7;

    typedef logic [FQ_WIDTH-1:0] fq_angle_t;

    localparam logic [FQ_WIDTH-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
        7'd0,7'd1,7'd2,7'd3,7'd4,7'd4,7'd5,7'd6,7'd7,7'd8,7'd9,7'd10,7'd11,7'd11,
        7'd12,7'd13,7'd14,7'd15,7'd16,7'd17,7'd17,7'd18,7'd19,7'd20,7'd21,7'd21,
        7'd22,7'd23,7'd24,7'd24,7'd25,7'd26,7'd27,7'd27,7'd28,
        7'd29,7'd29,7'd30,7'd31,7'd31,7'd32,7'd33,7'd33,7'd34,7'd35,7'd35,7'd36,
        7'd36,7'd37,7'd37,7'd38,7'd39,7'd39,7'd40,7'd40,7'd41,
        7'd41,7'd42,7'd42,7'd43,7'd43,7'd44,7'd44,7'd45,7'd45,7'd45,7'd46,7'd46,
        7'd47,7'd47,7'd48,7'd48,7'd48,7'd49,7'd49,7'd50,7'd50,
        7'd50,7'd51,7'd51,7'd51,7'd52,7'd52,7'd52,7'd53,7'd53,7'd53,7'd54,7'd54,
        7'd54,7'd55,7'd55,7'd55,7'd55,7'd56,7'd56,7'd56,7'd57,
        7'd57,7'd57,7'd57,7'd58,7'd58,7'd58,7'd58,7'd59,7'd59,7'd59,7'd59,7'd60,
        7'd60,7'd60,7'd60,7'd60,7'd61,7'd61,7'd61,7'd61,7'd62,
        7'd62,7'd62,7'd62,7'd62,7'd63,7'd63,7'd63,7'd63,7'd63,7'd63,7'd64,7'd64,
        7'd64,7'd64,7'd64,7'd64,7'd65,7'd65,7'd65,7'd65,7'd65,
        7'd65,7'd66,7'd66,7'd66,7'd66,7'd66,7'd66,7'd66,7'd67,7'd67,7'd67,7'd67,
        7'd67,7'd67,7'd67,7'd68,7'd68,7'd68,7'd68,7'd68,7'd68,
        7'd68,7'd68,7'd69,7'd69,7'd69,7'd69,7'd69,7'd69,7'd69,7'd69,7'd69,7'd70,
        7'd70,7'd70,7'd70,7'd70,7'd70,7'd70,7'd70,7'd70,7'd71,
        7'd71,7'd71,7'd71,7'd71,7'd71,7'd71,7'd71,7'd71,7'd71,7'd71,7'd72,7'd72,
        7'd72,7'd72,7'd72,7'd72,7'd72,7'd72,7'd72,7'd72,7'd72,
        7'd73,7'd73,7'd73,7'd73,7'd73,7'd73,7'd73,7'd73,7'd73,7'd73,7'd73,7'd73,
        7'd73,7'd73,7'd74,7'd74,7'd74,7'd74,7'd74,7'd74,7'd74,
        7'd74,7'd74,7'd74,7'd74,7'd74,7'd74,7'd74,7'd75,7'd75,7'd75,7'd75,7'd75,
        7'd75,7'd75,7'd75,7'd75,7'd75,7'd75,7'd75,7'd75,7'd75,
        7'd75,7'd75,7'd75,7'd76,7'd76,7'd76,7'd76,7'd76,7'd76,7'd76,7'd76,7'd76,
        7'd76,7'd76,7'd76,7'd76,7'd76,7'd76,7'd76,7'd76,7'd76,
        7'd76,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,
        7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,7'd77,
        7'd77,7'd77,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,
        7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,
        7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd78,7'd79,7'd79,7'd79,7'd79,7'd79,
        7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,
        7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,7'd79,
        7'd79,7'd79,7'd79,7'd79,7'd79
    };

    // steep angles from an index that is 346 or more
    function automatic fq_angle_t steep_angle(input logic [13:0] idx, input logic big);
        fq_angle_t a;
        begin
            if (big || idx > 14'd7334)     a = 7'd90;
            else if (idx > 14'd2444)       a = 7'd89;
            else if (idx > 14'd1465)       a = 7'd88;
            else if (idx > 14'd1046)       a = 7'd87;
            else if (idx > 14'd813)        a = 7'd86;
            else if (idx > 14'd664)        a = 7'd85;
            else if (idx > 14'd561)        a = 7'd84;
            else if (idx > 14'd486)        a = 7'd83;
            else if (idx > 14'd428)        a = 7'd82;
            else if (idx > 14'd382)        a = 7'd81;
            else                           a = 7'd80;
            steep_angle = a;
        end
    endfunction

endpackage

// ===== rtl/atan2_div.sv =====
// pipelined restoring divider, one quotient bit per stage, valid bits travel with data
module atan2_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 16,
    parameter int TAG_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quot,
    output logic [TAG_W-1:0] tag_out
);
    logic [NUM_W-1:0] num_reg [0:NUM_W];
    logic [DEN_W-1:0] rem_reg [0:NUM_W];
    logic [DEN_W-1:0] den_reg [0:NUM_W];
    logic [TAG_W-1:0] tag_reg [0:NUM_W];
    logic             vld_reg [0:NUM_W];

    assign num_reg[0] = num;
    assign rem_reg[0] = '0;
    assign den_reg[0] = den;
    assign tag_reg[0] = tag_in;
    assign vld_reg[0] = in_valid;

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DEN_W:0]   trial_next;
        logic [DEN_W:0]   diff_next;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] num_next;
        logic [DEN_W-1:0] rem_s_reg;
        logic [NUM_W-1:0] num_s_reg;
        logic [DEN_W-1:0] den_s_reg;
        logic [TAG_W-1:0] tag_s_reg;
        logic             vld_s_reg;

        always_comb
        begin
            trial_next = {rem_reg[s], num_reg[s][NUM_W-1]};
            diff_next  = trial_next - {1'b0, den_reg[s]};
            num_next   = {num_reg[s][NUM_W-2:0], ~diff_next[DEN_W]};
            rem_next   = diff_next[DEN_W] ? trial_next[DEN_W-1:0] : diff_next[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_s_reg <= 1'b0;
            else if (en)
                vld_s_reg <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_s_reg <= rem_next;
                num_s_reg <= num_next;
                den_s_reg <= den_reg[s];
                tag_s_reg <= tag_reg[s];
            end
        end

        assign rem_reg[s+1] = rem_s_reg;
        assign num_reg[s+1] = num_s_reg;
        assign den_reg[s+1] = den_s_reg;
        assign tag_reg[s+1] = tag_s_reg;
        assign vld_reg[s+1] = vld_s_reg;
    end

    assign out_valid = vld_reg[NUM_W];
    assign quot      = num_reg[NUM_W];
    assign tag_out   = tag_reg[NUM_W];
endmodule

// ===== rtl/atan2_degrees_lookup.sv =====
// top level: four-quadrant whole-degree arctangent, stream in and out
// path from input beat to output beat: stage 1 register, the divider stages, stage 2 register, output register
// throughput: one beat per cycle while the output is not stalled; the restoring divider has one stage per quotient bit
// the whole pipeline advances together; a final output register holds a beat under stall
// reset: asynchronous active low, clears every valid bit; data registers are not reset
module atan2_degrees_lookup #(
    parameter int SAMPLE_WIDTH = atan2_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // x_coord, y_coord
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // angle_deg
    output logic [15:0]               m_axis_tdata
);
    import atan2_pkg::*;

    localparam int MAG_W = SAMPLE_WIDTH + 1;
    localparam int NUM_W = MAG_W + SCALE_SHIFT;
    // quadrant tag: both zero, x zero, x negative, y negative
    localparam int TAG_W = 4;

    logic en;
    logic out_vld_reg;
    logic [ANGLE_WIDTH-1:0] out_angle_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: magnitudes and signs
    logic signed [SAMPLE_WIDTH-1:0] x_in, y_in;
    logic             s1_vld_reg;
    logic [MAG_W-1:0] s1_xm_reg, s1_ym_reg;
    logic [TAG_W-1:0] s1_tag_reg;

    assign x_in = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign y_in = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_xm_reg  <= x_in[SAMPLE_WIDTH-1] ? -{x_in[SAMPLE_WIDTH-1], x_in}
                                               : {1'b0, x_in};
            s1_ym_reg  <= y_in[SAMPLE_WIDTH-1] ? -{y_in[SAMPLE_WIDTH-1], y_in}
                                               : {1'b0, y_in};
            s1_tag_reg <= {y_in[SAMPLE_WIDTH-1], x_in[SAMPLE_WIDTH-1],
                           x_in == '0, (x_in == '0) && (y_in == '0)};
        end
    end

    // divider
    logic             dv_vld;
    logic [NUM_W-1:0] dv_quot;
    logic [TAG_W-1:0] dv_tag;

    atan2_div #(
        .NUM_W (NUM_W),
        .DEN_W (MAG_W),
        .TAG_W (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_vld_reg),
        .num       ({s1_ym_reg, {SCALE_SHIFT{1'b0}}}),
        .den       (s1_xm_reg),
        .tag_in    (s1_tag_reg),
        .out_valid (dv_vld),
        .quot      (dv_quot),
        .tag_out   (dv_tag)
    );

    // stage 2: table lookup and threshold chain
    logic             s2_vld_reg;
    fq_angle_t        s2_a_reg;
    logic [TAG_W-1:0] s2_tag_reg;
    logic             big_q;
    fq_angle_t        a_next;

    always_comb
    begin
        big_q = (NUM_W > 14) ? (dv_quot >> 14) != '0 : 1'b0;
        if (!big_q && dv_quot < NUM_W'(TABLE_LEN))
            a_next = ATAN_TABLE[dv_quot[TABLE_IDX_W-1:0]];
        else
            a_next = steep_angle(dv_quot[13:0], big_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_a_reg   <= a_next;
            s2_tag_reg <= dv_tag;
        end
    end

    // stage 3: quadrant
    logic signed [ANGLE_WIDTH-1:0] a_s, ang_next;

    always_comb
    begin
        a_s = ANGLE_WIDTH'(s2_a_reg);
        if (s2_tag_reg[0])
            ang_next = '0;
        else if (s2_tag_reg[1])
            ang_next = s2_tag_reg[3] ? -9'sd90 : 9'sd90;
        else if (!s2_tag_reg[2])
            ang_next = s2_tag_reg[3] ? -a_s : a_s;
        else if (!s2_tag_reg[3])
            ang_next = 9'sd180 - a_s;
        else
            ang_next = a_s - 9'sd180;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_angle_reg <= ang_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(16-ANGLE_WIDTH){1'b0}}, out_angle_reg};

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(out_angle_reg) <= 9'sd180) &&
                          ($signed(out_angle_reg) >= -9'sd180))
        else $error("angle out of range");
`endif
endmodule
